/* rtl/clcc_pkg.sv */
// shared constants and helpers for the camera log curve converter
package clcc_pkg;

  // sample field format
  localparam int SAMPLE_W = 20;

  // internal log/exp fraction width
  localparam int IW = 30;

  // curve constants in q30
  localparam logic [32:0] NEG_LOG2_SL   = 33'd5587146303;
  localparam logic [27:0] CODE_PER_LOG2 = 28'd157826414;
  localparam logic [32:0] LOG2_PER_CODE = 33'd7304997134;
  localparam logic [29:0] LN2_Q         = 30'd744261118;

  // sensor level mapping
  localparam int LEVEL_OFS   = 64;
  localparam int LEVEL_GAIN  = 3776;
  localparam int LEVEL_FLOOR = 37;
  // level gain split as odd factor times a power of two
  localparam int GAIN_ODD    = 59;
  localparam int GAIN_POW2   = 6;

  // code range, in units of 1/1024
  localparam int CODE_LO    = 3;
  localparam int CODE_HI    = 1020;
  localparam int CODE_SHIFT = 10;

  // exp series length
  localparam int TAYLOR_N = 12;

  // datapath latencies in enabled cycles
  localparam int FWD_LAT = 36;
  localparam int INV_LAT = 45;

  localparam logic signed [47:0] FIELD_MAX_W = (48'sd1 <<< (SAMPLE_W - 1)) - 48'sd1;
  localparam logic signed [47:0] FIELD_MIN_W = -(48'sd1 <<< (SAMPLE_W - 1));

  // saturate a wide signed value to the sample field
  function automatic logic [SAMPLE_W-1:0] sat_field(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = v;
    if (v > FIELD_MAX_W) begin
      r = FIELD_MAX_W;
    end else if (v < FIELD_MIN_W) begin
      r = FIELD_MIN_W;
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/clcc_cdiv.sv */
// two-stage exact division by a constant via reciprocal multiply and correction
module clcc_cdiv #(
  parameter int W   = 31,
  parameter int DIV = 3
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] a_i,
  output logic [W-1:0] q_o
);

  localparam logic [W:0]   RECIP = (W+1)'((64'd1 << W) / DIV);
  localparam logic [W-1:0] DIV_W = W'(DIV);

  logic [2*W:0] prod;
  logic [W-1:0] a_q;
  logic [W-1:0] q0_q;
  logic [W-1:0] q_q;
  logic [W-1:0] rem;

  // estimate, at most one below the true quotient
  assign prod = (2*W+1)'(a_i) * (2*W+1)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_i;
      q0_q <= prod[2*W-1:W];
    end
  end

  // fix up the estimate
  assign rem = a_q - W'(q0_q * DIV_W);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= (rem >= DIV_W) ? q0_q + W'(1) : q0_q;
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/clcc_fwd.sv */
// forward path: linear sample to log code, log2 by repeated squaring
module clcc_fwd #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [clcc_pkg::SAMPLE_W-1:0] x_i,
  output logic        [clcc_pkg::SAMPLE_W-1:0] y_o
);

  localparam int IW  = clcc_pkg::IW;
  localparam int SW  = ((FRAC_BITS + 8 > 33) ? FRAC_BITS + 8 : 33) + 1;
  localparam int UW  = SW - 1;
  localparam int PW  = $clog2(UW);
  localparam int MW  = IW + 1;
  localparam int LGW = PW + IW;
  localparam int VW  = LGW - 1;
  localparam int PDW = VW + 28;
  localparam int PRW = PDW + 1;
  localparam int SH  = 2 * IW - FRAC_BITS;
  localparam int YW  = PRW - SH;

  localparam logic signed [SW-1:0] OFS   = SW'(longint'(clcc_pkg::LEVEL_OFS) << FRAC_BITS);
  localparam logic signed [SW-1:0] FLOOR = SW'(longint'(clcc_pkg::LEVEL_FLOOR) << FRAC_BITS);
  localparam logic signed [SW-1:0] GAIN  = SW'(clcc_pkg::LEVEL_GAIN);
  localparam logic [YW-1:0] LO =
    YW'(longint'(clcc_pkg::CODE_LO) << (FRAC_BITS - clcc_pkg::CODE_SHIFT));
  localparam logic [YW-1:0] HI =
    YW'(longint'(clcc_pkg::CODE_HI) << (FRAC_BITS - clcc_pkg::CODE_SHIFT));
  localparam logic [LGW-1:0] NEG_L = LGW'(clcc_pkg::NEG_LOG2_SL);

  logic signed [SW-1:0] x_ext;
  logic signed [SW-1:0] s_d;
  logic [UW-1:0]  s1_q;
  logic           low1_q;
  logic [PW-1:0]  p2_d;
  logic [UW-1:0]  s2_q;
  logic [PW-1:0]  p2_q;
  logic           low2_q;
  logic [UW-1:0]  norm;
  logic [MW-1:0]  sq_m_q [IW+1];
  logic [IW-1:0]  sq_f_q [IW+1];
  logic [PW-1:0]  sq_p_q [IW+1];
  logic           sq_l_q [IW+1];
  logic [MW-1:0]  nm     [IW];
  logic [IW-1:0]  nf     [IW];
  logic [LGW-1:0] lg;
  logic [VW-1:0]  v_q;
  logic           low_v_q;
  logic [PDW-1:0] prod_q;
  logic           low_p_q;
  logic [PRW-1:0] rsum;
  logic [YW-1:0]  yr;
  logic [YW-1:0]  yc;
  logic [clcc_pkg::SAMPLE_W-1:0] y_q;

  // sensor level and low-level test
  assign x_ext = {{(SW - clcc_pkg::SAMPLE_W){x_i[clcc_pkg::SAMPLE_W-1]}}, x_i};
  assign s_d   = x_ext * GAIN + OFS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= s_d[UW-1:0];
      low1_q <= (s_d <= FLOOR);
    end
  end

  // leading one position
  always_comb begin
    p2_d = '0;
    for (int i = 0; i < UW; i++) begin
      if (s1_q[i]) begin
        p2_d = PW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q   <= s1_q;
      p2_q   <= p2_d;
      low2_q <= low1_q;
    end
  end

  // normalize mantissa to [1,2) in q30
  assign norm = s2_q << (PW'(UW - 1) - p2_q);

  // one squaring round per stage
  always_comb begin
    logic [2*MW-1:0] sqr;
    logic [MW:0]     t;
    for (int i = 0; i < IW; i++) begin
      sqr   = sq_m_q[i] * sq_m_q[i];
      t     = sqr[2*MW-1:IW];
      nm[i] = t[MW] ? t[MW:1] : t[MW-1:0];
      nf[i] = {sq_f_q[i][IW-2:0], t[MW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_m_q[0] <= norm[UW-1 -: MW];
      sq_f_q[0] <= '0;
      sq_p_q[0] <= p2_q;
      sq_l_q[0] <= low2_q;
      for (int i = 0; i < IW; i++) begin
        sq_m_q[i+1] <= nm[i];
        sq_f_q[i+1] <= nf[i];
        sq_p_q[i+1] <= sq_p_q[i];
        sq_l_q[i+1] <= sq_l_q[i];
      end
    end
  end

  // log2 minus curve offset, clamped at zero
  assign lg = {PW'(sq_p_q[IW] - PW'(FRAC_BITS)), sq_f_q[IW]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q     <= (lg < NEG_L) ? '0 : VW'(lg - NEG_L);
      low_v_q <= sq_l_q[IW];
    end
  end

  // scale to code
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= PDW'(v_q) * PDW'(clcc_pkg::CODE_PER_LOG2);
      low_p_q <= low_v_q;
    end
  end

  // round half up, clamp to code range, saturate
  assign rsum = PRW'(prod_q) + (PRW'(1) << (SH - 1));
  assign yr   = rsum[PRW-1:SH];
  assign yc   = (yr < LO) ? LO : ((yr > HI) ? HI : yr);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= low_p_q ? '0 : clcc_pkg::sat_field($signed(48'(yc)));
    end
  end

  assign y_o = y_q;

endmodule

/* rtl/clcc_inv.sv */
// inverse path: log code to linear sample, exp2 by a pipelined series
module clcc_inv #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [clcc_pkg::SAMPLE_W-1:0] x_i,
  output logic        [clcc_pkg::SAMPLE_W-1:0] y_o
);

  localparam int IW   = clcc_pkg::IW;
  localparam int CW   = 32;
  localparam int PMW  = IW + 33;
  localparam int UW   = 34;
  localparam int TW   = IW + 1;
  localparam int ZW   = IW;
  localparam int SUMW = IW + 2;
  localparam int KW   = 4;
  localparam int LEVW = SUMW + 15;
  localparam int NW   = LEVW + 1;
  localparam int DSH  = clcc_pkg::GAIN_POW2 + IW - FRAC_BITS;
  localparam int AW   = FRAC_BITS + 7;
  localparam int N    = clcc_pkg::TAYLOR_N;

  localparam logic signed [CW-1:0] LO =
    CW'(longint'(clcc_pkg::CODE_LO) << (FRAC_BITS - clcc_pkg::CODE_SHIFT));
  localparam logic signed [CW-1:0] HI =
    CW'(longint'(clcc_pkg::CODE_HI) << (FRAC_BITS - clcc_pkg::CODE_SHIFT));
  localparam logic signed [NW-1:0] LEV_OFS =
    NW'(longint'(clcc_pkg::LEVEL_OFS) << IW);
  localparam logic [NW-1:0] HALF_D = NW'(longint'(clcc_pkg::GAIN_ODD) << (DSH - 1));

  logic signed [CW-1:0] x_ext;
  logic signed [CW-1:0] xc;
  logic [CW-1:0]   xsh;
  logic [IW-1:0]   xq_q;
  logic [PMW-1:0]  pm_q;
  logic [UW-1:0]   u;
  logic [KW-1:0]   k3_q;
  logic [IW-1:0]   f3_q;
  logic [2*IW-1:0] zp;
  logic [ZW-1:0]   z4_q;
  logic [KW-1:0]   k4_q;
  logic [TW-1:0]   t_w [N+1];
  logic [ZW-1:0]   z_w [N+1];
  logic [KW-1:0]   k_w [N+1];
  logic [SUMW-1:0] s_w [N+1];
  logic [SUMW-1:0] sumf_q;
  logic [KW-1:0]   kf_q;
  logic [LEVW-1:0] lev;
  logic signed [NW-1:0] num;
  logic [NW-1:0]   mag;
  logic [NW-1:0]   mag_q;
  logic            neg_q;
  logic            neg_b_q;
  logic            neg_c_q;
  logic [AW-1:0]   qd;
  logic signed [47:0] ys;
  logic [clcc_pkg::SAMPLE_W-1:0] y_q;

  // clamp code, move to q30
  assign x_ext = {{(CW - clcc_pkg::SAMPLE_W){x_i[clcc_pkg::SAMPLE_W-1]}}, x_i};
  assign xc    = (x_ext < LO) ? LO : ((x_ext > HI) ? HI : x_ext);
  assign xsh   = CW'(xc) << (IW - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xq_q <= xsh[IW-1:0];
    end
  end

  // code to log2 of level
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q <= PMW'(xq_q) * PMW'(clcc_pkg::LOG2_PER_CODE);
    end
  end

  assign u = UW'(pm_q[PMW-1:IW]) + UW'(clcc_pkg::NEG_LOG2_SL);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k3_q <= u[UW-1:IW];
      f3_q <= u[IW-1:0];
    end
  end

  // series argument f*ln2
  assign zp = (2*IW)'(f3_q) * (2*IW)'(clcc_pkg::LN2_Q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z4_q <= zp[2*IW-1:IW];
      k4_q <= k3_q;
    end
  end

  assign t_w[0] = TW'(1) << IW;
  assign z_w[0] = z4_q;
  assign k_w[0] = k4_q;
  assign s_w[0] = '0;

  // one series term per three stages: multiply, then divide by term index
  for (genvar j = 0; j < N; j++) begin : g_term
    logic [TW+ZW-1:0] prod;
    logic [TW-1:0]    a_q;
    logic [TW-1:0]    q;
    logic [ZW-1:0]    z_a_q, z_b_q, z_c_q;
    logic [KW-1:0]    k_a_q, k_b_q, k_c_q;
    logic [SUMW-1:0]  s_a_q, s_b_q, s_c_q;

    assign prod = (TW+ZW)'(t_w[j]) * (TW+ZW)'(z_w[j]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q   <= prod[TW+ZW-1:IW];
        z_a_q <= z_w[j];
        k_a_q <= k_w[j];
        s_a_q <= s_w[j] + SUMW'(t_w[j]);
        z_b_q <= z_a_q;
        k_b_q <= k_a_q;
        s_b_q <= s_a_q;
        z_c_q <= z_b_q;
        k_c_q <= k_b_q;
        s_c_q <= s_b_q;
      end
    end

    clcc_cdiv #(
      .W  (TW),
      .DIV(j + 1)
    ) u_div (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (a_q),
      .q_o  (q)
    );

    assign t_w[j+1] = q;
    assign z_w[j+1] = z_c_q;
    assign k_w[j+1] = k_c_q;
    assign s_w[j+1] = s_c_q;
  end

  // add last term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sumf_q <= s_w[N] + SUMW'(t_w[N]);
      kf_q   <= k_w[N];
    end
  end

  // level minus offset, magnitude with half divisor added
  assign lev = LEVW'(sumf_q) << kf_q;
  assign num = $signed(NW'(lev)) - LEV_OFS;
  assign mag = (num[NW-1] ? NW'(-num) : NW'(num)) + HALF_D;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag;
      neg_q <= num[NW-1];
    end
  end

  // divide by the odd part of the gain, power of two already shifted out
  clcc_cdiv #(
    .W  (AW),
    .DIV(clcc_pkg::GAIN_ODD)
  ) u_gain_div (
    .clk_i(clk_i),
    .en_i (en_i),
    .a_i  (AW'(mag_q >> DSH)),
    .q_o  (qd)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_b_q <= neg_q;
      neg_c_q <= neg_b_q;
    end
  end

  // restore sign and saturate
  assign ys = neg_c_q ? -$signed(48'(qd)) : $signed(48'(qd));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= clcc_pkg::sat_field(ys);
    end
  end

  assign y_o = y_q;

endmodule

/* rtl/camera_log_curve_convert.sv */
// top level of the camera log curve converter
// throughput: one sample per clock while the output is not held; the exp series sets the depth
// a held output stalls the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and selects the forward (linear to log) direction
module camera_log_curve_convert #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_inverse_mode_i,
  input  logic                                 sample_in_valid_i,
  output logic                                 sample_in_ready_o,
  input  logic signed [clcc_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                 sample_out_valid_o,
  input  logic                                 sample_out_ready_i,
  output logic signed [clcc_pkg::SAMPLE_W-1:0] sample_out_o
);

  localparam int L   = clcc_pkg::INV_LAT;
  localparam int PAD = clcc_pkg::INV_LAT - clcc_pkg::FWD_LAT;
  localparam int SW  = clcc_pkg::SAMPLE_W;

  logic          en;
  logic          in_acc;
  logic          mode_q;
  logic [L-1:0]  vld_q;
  logic [L-1:0]  vld_d;
  logic [SW-1:0] fwd_y;
  logic [SW-1:0] inv_y;
  logic [SW-1:0] pad_q [PAD];
  logic          out_vld_q;
  logic [SW-1:0] out_q;

  // pipeline advances unless a result is held
  assign en                = !out_vld_q || sample_out_ready_i;
  assign sample_in_ready_o = en;
  assign in_acc            = sample_in_valid_i && en;
  assign cfg_ready_o       = 1'b1;

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_inverse_mode_i;
    end
  end

  // valid bits travel with the data
  assign vld_d = {vld_q[L-2:0], in_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[L-1];
    end
  end

  clcc_fwd #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fwd (
    .clk_i(clk_i),
    .en_i (en),
    .x_i  (sample_in_i),
    .y_o  (fwd_y)
  );

  clcc_inv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_inv (
    .clk_i(clk_i),
    .en_i (en),
    .x_i  (sample_in_i),
    .y_o  (inv_y)
  );

  // align forward result with inverse path, then output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      pad_q[0] <= fwd_y;
      for (int i = 1; i < PAD; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
      out_q <= mode_q ? inv_y : pad_q[PAD-1];
    end
  end

  assign sample_out_valid_o = out_vld_q;
  assign sample_out_o       = out_q;

  // checks
  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q[0])
    else $error("accepted request not tracked");

  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[L-1] && en |=> sample_out_valid_o)
    else $error("finished request did not reach output");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_fwd_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !mode_q |-> !sample_out_o[SW-1])
    else $error("negative log code");

endmodule

/* test/tb_camera_log_curve_convert.sv */
// self-checking testbench for the camera log curve converter
module tb_camera_log_curve_convert;

  localparam int FB = 16;
  localparam int NUM_RANDOM = 880;
  localparam int SETTLE_CYCLES = 60;
  localparam int SW = clcc_pkg::SAMPLE_W;
  localparam int QW = clcc_pkg::IW;

  localparam longint unsigned Q_ONE = 64'd1 << QW;
  localparam longint unsigned OFS_LOG2 = 64'd5587146303;
  localparam longint unsigned CODE_GAIN = 64'd157826414;
  localparam longint unsigned LOG2_GAIN = 64'd7304997134;
  localparam longint unsigned LN2_VAL = 64'd744261118;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_inverse;
  logic in_valid;
  logic in_ready;
  logic signed [SW-1:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic signed [SW-1:0] out_sample;

  int errors = 0;
  logic inverse_sel = 1'b0;
  bit quiet_out = 1'b0;

  camera_log_curve_convert #(.FRAC_BITS(FB)) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_inverse_mode_i(cfg_inverse),
    .sample_in_valid_i(in_valid),
    .sample_in_ready_o(in_ready),
    .sample_in_i(in_sample),
    .sample_out_valid_o(out_valid),
    .sample_out_ready_i(out_ready),
    .sample_out_o(out_sample)
  );

  // mismatch report, one line each
  task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                 input logic [SW-1:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  // log2 of a positive level with FB fraction bits, signed q30
  function automatic longint log2_level(input longint unsigned s);
    int p;
    longint unsigned t;
    longint unsigned m;
    longint unsigned frac;
    p = 0;
    t = s;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      p++;
    end
    if (p >= QW) m = s >> (p - QW);
    else m = s << (QW - p);
    for (int i = 0; i < QW; i++) begin
      m = (m * m) >> QW;
      frac = frac << 1;
      if (m >= 2 * Q_ONE) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - FB) * longint'(Q_ONE) + longint'(frac);
  endfunction

  // 2^f for a q30 fraction by a truncated taylor series
  function automatic longint unsigned pow2_frac(input longint unsigned f);
    longint unsigned z;
    longint unsigned sum;
    longint unsigned term;
    z = (f * LN2_VAL) >> QW;
    sum = Q_ONE;
    term = Q_ONE;
    for (int n = 1; n <= clcc_pkg::TAYLOR_N; n++) begin
      term = ((term * z) >> QW) / n;
      sum += term;
    end
    return sum;
  endfunction

  // expected converted sample for the current direction
  function automatic logic [SW-1:0] convert_sample(input logic signed [SW-1:0] xin,
                                                   input logic inv);
    longint x;
    longint lo;
    longint hi;
    longint y;
    longint s;
    longint v;
    longint unsigned prod;
    longint unsigned xq;
    longint unsigned u;
    longint unsigned lev;
    longint unsigned d;
    longint num;
    int k;
    int sh;
    x = xin;
    lo = longint'(clcc_pkg::CODE_LO) << (FB - clcc_pkg::CODE_SHIFT);
    hi = longint'(clcc_pkg::CODE_HI) << (FB - clcc_pkg::CODE_SHIFT);
    sh = 2 * QW - FB;
    if (!inv) begin
      s = (longint'(clcc_pkg::LEVEL_OFS) << FB) + x * clcc_pkg::LEVEL_GAIN;
      if (s <= (longint'(clcc_pkg::LEVEL_FLOOR) << FB)) begin
        y = 0;
      end else begin
        v = log2_level(longint'(s)) - longint'(OFS_LOG2);
        if (v < 0) v = 0;
        prod = longint'(v) * CODE_GAIN;
        y = longint'((prod + (64'd1 << (sh - 1))) >> sh);
        if (y < lo) y = lo;
        if (y > hi) y = hi;
      end
    end else begin
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      xq = longint'(x) << (QW - FB);
      u = ((xq * LOG2_GAIN) >> QW) + OFS_LOG2;
      k = int'((u >> QW) & 15);
      lev = pow2_frac(u & (Q_ONE - 1)) << k;
      num = longint'(lev) - longint'(64 * Q_ONE);
      d = 64'd3776 << (QW - FB);
      if (num >= 0) y = longint'((longint'(num) + d / 2) / d);
      else y = -longint'((longint'(-num) + d / 2) / d);
    end
    return clcc_pkg::sat_field(48'(y));
  endfunction

  // expected results in acceptance order
  class curve_scoreboard;
    logic [SW-1:0] pending_codes[$];

    function void note_request(input logic signed [SW-1:0] x, input logic inv);
      pending_codes.push_back(convert_sample(x, inv));
    endfunction

    task check_result(input logic [SW-1:0] got);
      logic [SW-1:0] want;
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected sample_out", got, '0);
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) report_mismatch("sample_out", got, want);
      end
    endtask
  endclass

  curve_scoreboard board = new();

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("camera_log_curve_convert regression: fail");
    $finish;
  end

  // output monitor and check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_sample);
  end

  // output stall pattern
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 28);
    end
  end

  // send one sample request with random lead-in idling
  task automatic send_sample(input logic signed [SW-1:0] x, input bit no_gaps);
    if (!no_gaps) begin
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(x, inverse_sel);
  endtask

  // wait for the pipeline to drain
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the direction register while idle
  task automatic write_direction(input logic inv);
    drain();
    cfg_valid <= 1'b1;
    cfg_inverse <= inv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    inverse_sel = inv;
    cfg_valid <= 1'b0;
  endtask

  // random sample biased toward the interesting range of each direction
  function automatic logic signed [SW-1:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return SW'($urandom);
    if (sel < 4) return SW'($urandom_range(131072)) - 20'sd65536;
    if (sel < 6) return SW'($urandom_range(65536));
    return SW'($urandom_range(1200));
  endfunction

  initial begin
    logic signed [SW-1:0] edges[$];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_inverse = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners in both directions, starting with the reset direction
    edges = '{20'sh7FFFF, 20'sh80000, 20'sd0, 20'sd65536, -20'sd1, 20'sd1,
              -20'sd470, -20'sd469, -20'sd468, 20'sd192, 20'sd191, 20'sd63744,
              20'sd65280, 20'sd65281, -20'sd65536};
    foreach (edges[i]) send_sample(edges[i], 1'b0);
    write_direction(1'b1);
    foreach (edges[i]) send_sample(edges[i], 1'b0);
    write_direction(1'b0);

    // random phases over both directions
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_direction(ph[0]);
      for (int n = 0; n < NUM_RANDOM / 6; n++) begin
        // one long burst without gaps on either side
        quiet_out = (ph == 2 && n < 80);
        send_sample(pick_sample(), quiet_out);
        // sender holds off until everything is back
        if (ph == 3 && n == 40) drain();
      end
      quiet_out = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("camera_log_curve_convert regression: pass");
    end else begin
      $display("camera_log_curve_convert regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/clcc_pkg.sv
rtl/clcc_cdiv.sv
rtl/clcc_fwd.sv
rtl/clcc_inv.sv
rtl/camera_log_curve_convert.sv
test/tb_camera_log_curve_convert.sv
